[hw/rtl/ara_pkg.sv]
// Package with the shared constants, codes and controller/datapath interface types.
package ara_pkg;

  localparam int MAX_REGIONS_DEF = 32;
  localparam int ENTRY_W = 96;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_DEL    = 3'd1;
  localparam logic [2:0] MODE_DELALL = 3'd2;
  localparam logic [2:0] MODE_VERIFY = 3'd3;
  localparam logic [2:0] MODE_ALLOC  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_BEYOND   = 3'd4;
  localparam logic [2:0] ST_OVERLAP  = 3'd5;
  localparam logic [2:0] ST_WRAP     = 3'd6;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD_INIT,
    CMD_ADD_RD,
    CMD_ADD_EV,
    CMD_SHF_INIT,
    CMD_SHF_RD,
    CMD_SHF_EV,
    CMD_INS,
    CMD_CMP_RD,
    CMD_CMP_EV,
    CMD_CMP_END,
    CMD_ALC_RD,
    CMD_ALC_EV,
    CMD_FIN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic wrap;
    logic beyond;
    logic scan_end;
    logic start_le;
    logic overlap;
    logic shift_done;
    logic not_found;
    logic alc_end;
    logic fit;
    logic out_free;
  } dp_sts_t;

endpackage

[hw/rtl/ara_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module ara_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/ara_ctrl.sv]
// Controller state machine that sequences table scans, shifts and result delivery.
module ara_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_mode,
  output logic             in_stall,
  input  ara_pkg::dp_sts_t sts,
  output ara_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_CHK, S_ADD_RD, S_ADD_EV, S_ADD_OVL, S_SHF_RD, S_SHF_EV,
    S_CMP_RD, S_CMP_EV, S_ALC_RD, S_ALC_EV, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd.op    = ara_pkg::CMD_NONE;
    cmd.st    = st_r;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = ara_pkg::CMD_LOAD;
          case (in_mode) inside
            ara_pkg::MODE_ADD: state_nxt = S_ADD_CHK;
            ara_pkg::MODE_DEL, ara_pkg::MODE_DELALL, ara_pkg::MODE_VERIFY:
              state_nxt = S_CMP_RD;
            ara_pkg::MODE_ALLOC: state_nxt = S_ALC_RD;
            default: begin
              st_nxt    = ara_pkg::ST_OK;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_ADD_CHK: begin
        state_nxt = S_FIN;
        if (sts.full) begin
          st_nxt = ara_pkg::ST_FULL;
        end else if (sts.wrap) begin
          st_nxt = ara_pkg::ST_WRAP;
        end else if (sts.beyond) begin
          st_nxt = ara_pkg::ST_BEYOND;
        end else begin
          cmd.op    = ara_pkg::CMD_ADD_INIT;
          state_nxt = S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        if (sts.scan_end) begin
          state_nxt = S_ADD_OVL;
        end else begin
          cmd.op    = ara_pkg::CMD_ADD_RD;
          state_nxt = S_ADD_EV;
        end
      end
      S_ADD_EV: begin
        cmd.op    = ara_pkg::CMD_ADD_EV;
        state_nxt = sts.start_le ? S_ADD_RD : S_ADD_OVL;
      end
      S_ADD_OVL: begin
        if (sts.overlap) begin
          st_nxt    = ara_pkg::ST_OVERLAP;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = ara_pkg::CMD_SHF_INIT;
          state_nxt = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        if (sts.shift_done) begin
          cmd.op    = ara_pkg::CMD_INS;
          st_nxt    = ara_pkg::ST_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = ara_pkg::CMD_SHF_RD;
          state_nxt = S_SHF_EV;
        end
      end
      S_SHF_EV: begin
        cmd.op    = ara_pkg::CMD_SHF_EV;
        state_nxt = S_SHF_RD;
      end
      S_CMP_RD: begin
        if (sts.scan_end) begin
          cmd.op    = ara_pkg::CMD_CMP_END;
          st_nxt    = sts.not_found ? ara_pkg::ST_NOTFOUND : ara_pkg::ST_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = ara_pkg::CMD_CMP_RD;
          state_nxt = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        cmd.op    = ara_pkg::CMD_CMP_EV;
        state_nxt = S_CMP_RD;
      end
      S_ALC_RD: begin
        if (sts.alc_end) begin
          st_nxt    = ara_pkg::ST_NOSPACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = ara_pkg::CMD_ALC_RD;
          state_nxt = S_ALC_EV;
        end
      end
      S_ALC_EV: begin
        cmd.op    = ara_pkg::CMD_ALC_EV;
        state_nxt = sts.fit ? S_ADD_CHK : S_ALC_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = ara_pkg::CMD_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ara_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

[hw/rtl/ara_dp.sv]
// Datapath: operand registers, region table RAM, compares and the result register.
module ara_dp #(
  parameter int MAX_REGIONS = ara_pkg::MAX_REGIONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ara_pkg::dp_cmd_t cmd,
  output ara_pkg::dp_sts_t sts,
  input  logic [31:0]      ram_start,
  input  logic [31:0]      ram_size,
  input  logic [2:0]       in_mode,
  input  logic [31:0]      in_region_start,
  input  logic [31:0]      in_region_size,
  input  logic [31:0]      in_region_flags,
  input  logic [31:0]      in_flag_mask,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_alloc_address,
  output logic             out_hit,
  output logic [5:0]       out_removed_count,
  output logic [5:0]       out_used_count
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AW = $clog2(MAX_REGIONS);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_REGIONS);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [2:0]    mode_r;
  logic [32:0]   start_r;
  logic [31:0]   size_r, flags_r, mask_r;
  logic [CW-1:0] idx_r, widx_r, count_r, removed_r;
  logic [32:0]   prev_end_r, hi_r;
  logic [31:0]   next_start_r, addr_r;
  logic          has_next_r, found_r;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [31:0]   out_addr_r;
  logic          out_hit_r;
  logic [CW-1:0] out_removed_r, out_used_r;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [ara_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [31:0]          rd_start, rd_size, rd_flags;
  logic [CW-1:0]        idx_m1, widx_m1;

  logic [33:0] end34;
  logic [32:0] ram_end, rd_end, gap;
  logic        exact, match, keep;
  logic [CW+5:0] used_ext, removed_ext;

  assign {rd_start, rd_size, rd_flags} = ram_rdata;
  assign idx_m1   = idx_r - ONE_C;
  assign widx_m1  = widx_r - ONE_C;
  assign end34    = {1'b0, start_r} + {2'b0, size_r};
  assign ram_end  = {1'b0, ram_start} + {1'b0, ram_size};
  assign rd_end   = {1'b0, rd_start} + {1'b0, rd_size};
  assign gap      = hi_r - rd_end;
  assign exact    = (rd_start == start_r[31:0]) && (rd_size == size_r) &&
                    (rd_flags == flags_r);
  assign match    = (mode_r == ara_pkg::MODE_DELALL) ? ((rd_flags & mask_r) == flags_r)
                                                     : (exact && !found_r);
  assign keep     = !match && (mode_r != ara_pkg::MODE_VERIFY);

  always_comb begin
    sts.full       = (count_r >= MAX_C);
    sts.wrap       = start_r[32] || (end34 > 34'h1_0000_0000);
    sts.beyond     = (start_r < {1'b0, ram_start}) || (end34 > {1'b0, ram_end});
    sts.scan_end   = (idx_r == count_r);
    sts.start_le   = ({1'b0, rd_start} <= start_r);
    sts.overlap    = ((idx_r != '0) && (prev_end_r > start_r)) ||
                     (has_next_r && (end34 > {2'b0, next_start_r}));
    sts.shift_done = (widx_r == idx_r);
    sts.not_found  = (mode_r == ara_pkg::MODE_DEL) && !found_r;
    sts.alc_end    = (idx_r == '0);
    sts.fit        = (hi_r >= rd_end) && (gap >= {1'b0, size_r});
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = widx_r[AW-1:0];
    ram_wdata = ram_rdata;
    case (cmd.op)
      ara_pkg::CMD_ADD_RD, ara_pkg::CMD_CMP_RD: ram_re = 1'b1;
      ara_pkg::CMD_SHF_RD: begin
        ram_re    = 1'b1;
        ram_raddr = widx_m1[AW-1:0];
      end
      ara_pkg::CMD_ALC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_m1[AW-1:0];
      end
      ara_pkg::CMD_SHF_EV: ram_we = 1'b1;
      ara_pkg::CMD_CMP_EV: ram_we = keep;
      ara_pkg::CMD_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = {start_r[31:0], size_r, flags_r};
      end
      default: ;
    endcase
  end

  ara_ram #(
    .WIDTH(ara_pkg::ENTRY_W),
    .DEPTH(MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operand and scan registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      ara_pkg::CMD_LOAD: begin
        mode_r     <= in_mode;
        start_r    <= {1'b0, in_region_start};
        size_r     <= in_region_size;
        flags_r    <= in_region_flags;
        mask_r     <= in_flag_mask;
        idx_r      <= (in_mode == ara_pkg::MODE_ALLOC) ? count_r : '0;
        widx_r     <= '0;
        removed_r  <= '0;
        found_r    <= 1'b0;
        hi_r       <= ram_end;
        addr_r     <= '0;
        has_next_r <= 1'b0;
      end
      ara_pkg::CMD_ADD_INIT: begin
        idx_r      <= '0;
        has_next_r <= 1'b0;
      end
      ara_pkg::CMD_ADD_EV: begin
        if (sts.start_le) begin
          prev_end_r <= rd_end;
          idx_r      <= idx_r + ONE_C;
        end else begin
          next_start_r <= rd_start;
          has_next_r   <= 1'b1;
        end
      end
      ara_pkg::CMD_SHF_INIT: widx_r <= count_r;
      ara_pkg::CMD_SHF_EV:   widx_r <= widx_m1;
      ara_pkg::CMD_INS: begin
        if (mode_r == ara_pkg::MODE_ALLOC) begin
          addr_r <= start_r[31:0];
        end
      end
      ara_pkg::CMD_CMP_EV: begin
        idx_r <= idx_r + ONE_C;
        if (mode_r == ara_pkg::MODE_VERIFY) begin
          if (exact) begin
            found_r <= 1'b1;
          end
        end else if (match) begin
          found_r   <= 1'b1;
          removed_r <= removed_r + ONE_C;
        end else begin
          widx_r <= widx_r + ONE_C;
        end
      end
      ara_pkg::CMD_ALC_EV: begin
        if (sts.fit) begin
          start_r <= hi_r - {1'b0, size_r};
        end else begin
          hi_r  <= {1'b0, rd_start};
          idx_r <= idx_m1;
        end
      end
      default: ;
    endcase
  end

  // Entry count and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == ara_pkg::CMD_INS) begin
        count_r <= count_r + ONE_C;
      end else if (cmd.op == ara_pkg::CMD_CMP_END && mode_r != ara_pkg::MODE_VERIFY) begin
        count_r <= widx_r;
      end
      if (cmd.op == ara_pkg::CMD_FIN) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ara_pkg::CMD_FIN) begin
      out_status_r  <= cmd.st;
      out_addr_r    <= addr_r;
      out_hit_r     <= (mode_r == ara_pkg::MODE_VERIFY) && found_r;
      out_removed_r <= removed_r;
      out_used_r    <= count_r;
    end
  end

  assign used_ext          = {6'b0, out_used_r};
  assign removed_ext       = {6'b0, out_removed_r};
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_address = out_addr_r;
  assign out_hit           = out_hit_r;
  assign out_removed_count = removed_ext[5:0];
  assign out_used_count    = used_ext[5:0];

endmodule

[hw/rtl/address_region_allocator.sv]
// Top level of the sorted region table allocator: configuration registers and core wiring.
// Delete, delete all and verify walk all entries in use before raising out_valid; add
// ends early on a full, wrap or beyond-RAM error, else scans for its place, checks overlap
// and shifts the entries above it. Allocate walks the table down and then adds. Each
// table step is a RAM read plus an evaluate step through the single read port.
// Throughput: one item at a time; the next item is taken once the result is in the output
// register. Reset (rst_n low, synchronous) empties the table and clears ram_start, ram_size.
// No clearing pass is needed: only entries below the entry count are ever read.
module address_region_allocator #(
  parameter int MAX_REGIONS = ara_pkg::MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_region_start,
  input  logic [31:0] in_region_size,
  input  logic [31:0] in_region_flags,
  input  logic [31:0] in_flag_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_alloc_address,
  output logic        out_hit,
  output logic [5:0]  out_removed_count,
  output logic [5:0]  out_used_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers. Address bit 2 selects the register: ram_start at 0x0 and
  // ram_size at 0x4. The port never waits, so pready is tied high.
  logic [31:0] ram_start_r, ram_size_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? ram_size_r : ram_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_start_r <= '0;
      ram_size_r  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        ram_size_r <= pwdata;
      end else begin
        ram_start_r <= pwdata;
      end
    end
  end

  // The controller walks the table one entry per step; the datapath holds the table,
  // the operand copy of the item and the result register.
  ara_pkg::dp_cmd_t cmd;
  ara_pkg::dp_sts_t sts;

  ara_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ara_dp #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .ram_start         (ram_start_r),
    .ram_size          (ram_size_r),
    .in_mode           (in_mode),
    .in_region_start   (in_region_start),
    .in_region_size    (in_region_size),
    .in_region_flags   (in_region_flags),
    .in_flag_mask      (in_flag_mask),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_alloc_address (out_alloc_address),
    .out_hit           (out_hit),
    .out_removed_count (out_removed_count),
    .out_used_count    (out_used_count)
  );

endmodule

[hw/rtl/ara_checker.sv]
// Port-level checker for the allocator and its bind to the top level.
module ara_checker #(
  parameter int MAX_REGIONS = ara_pkg::MAX_REGIONS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_alloc_address,
  input logic        out_hit,
  input logic [5:0]  out_used_count
);

  localparam logic [8:0] MAX_C = 9'(MAX_REGIONS);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_used_count)))
    else $error("stalled result changed");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ara_pkg::ST_OK) |-> (out_alloc_address == 32'd0))
    else $error("failed item reports an address");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status == ara_pkg::ST_OK))
    else $error("hit with error status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && MAX_C < 9'd64) |-> ({3'b0, out_used_count} <= MAX_C))
    else $error("used count beyond table size");

endmodule

bind address_region_allocator ara_checker #(.MAX_REGIONS(MAX_REGIONS)) u_ara_checker (.*);

[bench/tb_address_region_allocator.sv]
// Testbench for the sorted region table allocator: random and directed table operations.
`timescale 1ns / 1ps

module tb_address_region_allocator;

  localparam int NREG = 32;
  localparam logic [2:0] REG_RAM_START = 3'd0;
  localparam logic [2:0] REG_RAM_SIZE  = 3'd4;

  // One operation presented to the block.
  typedef struct {
    logic [2:0]  mode;
    logic [31:0] rstart;
    logic [31:0] rsize;
    logic [31:0] rflags;
    logic [31:0] mask;
  } op_item_t;

  // One result of the block.
  typedef struct {
    logic [2:0]  status;
    logic [31:0] addr;
    logic        hit;
    logic [5:0]  removed;
    logic [5:0]  used;
  } op_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [31:0] in_region_start;
  logic [31:0] in_region_size;
  logic [31:0] in_region_flags;
  logic [31:0] in_flag_mask;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_alloc_address;
  logic        out_hit;
  logic [5:0]  out_removed_count;
  logic [5:0]  out_used_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  address_region_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_region_start(in_region_start), .in_region_size(in_region_size),
    .in_region_flags(in_region_flags), .in_flag_mask(in_flag_mask),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_alloc_address(out_alloc_address), .out_hit(out_hit),
    .out_removed_count(out_removed_count), .out_used_count(out_used_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the region table and the RAM window.
  logic [31:0] tbl_start [NREG];
  logic [31:0] tbl_size  [NREG];
  logic [31:0] tbl_flags [NREG];
  int          tbl_count;
  logic [31:0] mem_base;
  logic [31:0] mem_len;

  op_item_t   pending_items[$];
  op_result_t expected_results[$];
  int         mismatches;
  int         accepted_items;
  int         send_idle_pct;
  int         recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [32:0] mem_top();
    return {1'b0, mem_base} + {1'b0, mem_len};
  endfunction

  function automatic void table_remove(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i + 1];
      tbl_size[i]  = tbl_size[i + 1];
      tbl_flags[i] = tbl_flags[i + 1];
    end
    tbl_count--;
  endfunction

  // Sorted insert with the full set of checks; returns the status code.
  function automatic logic [2:0] table_insert(logic [32:0] s, logic [31:0] sz,
                                              logic [31:0] fl);
    logic [32:0] e;
    int pos;
    e = s + {1'b0, sz};
    if (tbl_count >= NREG) return ara_pkg::ST_FULL;
    if (s[32] || e > 33'h1_0000_0000) return ara_pkg::ST_WRAP;
    if (s < {1'b0, mem_base} || e > mem_top()) return ara_pkg::ST_BEYOND;
    pos = 0;
    while (pos < tbl_count && {1'b0, tbl_start[pos]} <= s) pos++;
    if (pos > 0 && {1'b0, tbl_start[pos - 1]} + {1'b0, tbl_size[pos - 1]} > s)
      return ara_pkg::ST_OVERLAP;
    if (pos < tbl_count && e > {1'b0, tbl_start[pos]}) return ara_pkg::ST_OVERLAP;
    for (int i = tbl_count; i > pos; i--) begin
      tbl_start[i] = tbl_start[i - 1];
      tbl_size[i]  = tbl_size[i - 1];
      tbl_flags[i] = tbl_flags[i - 1];
    end
    tbl_start[pos] = s[31:0];
    tbl_size[pos]  = sz;
    tbl_flags[pos] = fl;
    tbl_count++;
    return ara_pkg::ST_OK;
  endfunction

  // Applies one operation to the shadow table and returns what the block should answer.
  function automatic op_result_t table_apply(op_item_t it);
    op_result_t r;
    int idx;
    logic [32:0] lo, hi;
    bit placed;
    r = '{ara_pkg::ST_OK, 32'd0, 1'b0, 6'd0, 6'd0};
    case (it.mode)
      ara_pkg::MODE_ADD: begin
        r.status = table_insert({1'b0, it.rstart}, it.rsize, it.rflags);
      end
      ara_pkg::MODE_DEL, ara_pkg::MODE_VERIFY: begin
        idx = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (idx < 0 && tbl_start[i] == it.rstart && tbl_size[i] == it.rsize &&
              tbl_flags[i] == it.rflags) idx = i;
        end
        if (it.mode == ara_pkg::MODE_VERIFY) r.hit = (idx >= 0);
        else if (idx >= 0) begin
          table_remove(idx);
          r.removed = 6'd1;
        end else r.status = ara_pkg::ST_NOTFOUND;
      end
      ara_pkg::MODE_DELALL: begin
        idx = 0;
        while (idx < tbl_count) begin
          if ((tbl_flags[idx] & it.mask) == it.rflags) begin
            table_remove(idx);
            r.removed++;
          end else idx++;
        end
      end
      ara_pkg::MODE_ALLOC: begin
        // Top-down first fit over the gaps above each region.
        placed = 1'b0;
        r.status = ara_pkg::ST_NOSPACE;
        for (int k = tbl_count - 1; k >= 0 && !placed; k--) begin
          lo = {1'b0, tbl_start[k]} + {1'b0, tbl_size[k]};
          hi = (k + 1 < tbl_count) ? {1'b0, tbl_start[k + 1]} : mem_top();
          if (hi >= lo && hi - lo >= {1'b0, it.rsize}) begin
            placed = 1'b1;
            r.status = table_insert(hi - {1'b0, it.rsize}, it.rsize, it.rflags);
            if (r.status == ara_pkg::ST_OK) r.addr = hi[31:0] - it.rsize;
          end
        end
      end
      default: ;
    endcase
    r.used = tbl_count[5:0];
    return r;
  endfunction

  // Driver: takes items from the pending queue, holds them while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(table_apply('{in_mode, in_region_start,
            in_region_size, in_region_flags, in_flag_mask}));
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op_item_t it;
          it = pending_items.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= it.mode;
          in_region_start <= it.rstart;
          in_region_size  <= it.rsize;
          in_region_flags <= it.rflags;
          in_flag_mask    <= it.mask;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
        end else begin
          op_result_t e;
          e = expected_results.pop_front();
          if (out_status !== e.status || out_alloc_address !== e.addr ||
              out_hit !== e.hit || out_removed_count !== e.removed ||
              out_used_count !== e.used) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: expected st=%0d addr=%h hit=%0d rm=%0d used=%0d,",
                        " got st=%0d addr=%h hit=%0d rm=%0d used=%0d"},
                       e.status, e.addr, e.hit, e.removed, e.used, out_status,
                       out_alloc_address, out_hit, out_removed_count, out_used_count);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Sets the RAM window in both the block and the shadow copy; only called while idle.
  task automatic set_window(logic [31:0] base, logic [31:0] len);
    cfg_write(REG_RAM_START, base);
    cfg_write(REG_RAM_SIZE, len);
    mem_base = base;
    mem_len  = len;
  endtask

  task automatic push_op(logic [2:0] m, logic [31:0] s, logic [31:0] sz,
                         logic [31:0] fl, logic [31:0] mk);
    pending_items.push_back('{m, s, sz, fl, mk});
  endtask

  // Waits for all queued items to be accepted and answered, then for the block to settle.
  // The second wait covers an item that was taken from the queue in the same cycle as the
  // first check and so was not yet visible on in_valid.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4 * NREG + 16) @(posedge clk);
    while (in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // One random phase: mostly adds, allocations and matching deletes within the window.
  task automatic random_phase(int count);
    logic [31:0] s, sz, fl;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      fl = $urandom_range(3) == 0 ? $urandom() : {30'd0, 2'($urandom_range(3))};
      sz = $urandom_range(3) == 0 ? $urandom() : $urandom_range(mem_len >> 4);
      s = mem_base + $urandom_range(mem_len);
      if (pick < 35) push_op(ara_pkg::MODE_ADD, s, sz, fl, $urandom());
      else if (pick < 60) push_op(ara_pkg::MODE_ALLOC, s, sz, fl, $urandom());
      else if (pick < 70 && tbl_count > 0) begin
        // Use a live entry so that deletes and verifies mostly hit.
        int k;
        k = $urandom_range(tbl_count - 1);
        push_op($urandom_range(1) ? ara_pkg::MODE_DEL : ara_pkg::MODE_VERIFY,
                tbl_start[k], tbl_size[k], tbl_flags[k], $urandom());
      end else if (pick < 80)
        push_op($urandom_range(1) ? ara_pkg::MODE_DEL : ara_pkg::MODE_VERIFY,
                s, sz, fl, $urandom());
      else if (pick < 86)
        push_op(ara_pkg::MODE_DELALL, s, sz, {30'd0, 2'($urandom_range(3))}, 32'h3);
      else if (pick < 90)
        push_op(ara_pkg::MODE_DELALL, s, sz, rand_word(), rand_word());
      else if (pick < 94) push_op(3'($urandom_range(5, 7)), rand_word(), rand_word(),
                                  rand_word(), rand_word());
      else push_op(3'($urandom_range(4)), rand_word(), rand_word(), rand_word(),
                   rand_word());
      // Keep the pending queue short so the table view above stays close to reality.
      while (pending_items.size() > 2) @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_mode = '0; in_region_start = '0; in_region_size = '0;
    in_region_flags = '0; in_flag_mask = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    tbl_count = 0; mem_base = '0; mem_len = '0;
    mismatches = 0; accepted_items = 0; send_idle_pct = 0; recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty window first, then full address space with edge cases.
    push_op(ara_pkg::MODE_ALLOC, 0, 0, 0, 0);
    push_op(ara_pkg::MODE_ADD, 0, 0, 0, 0);
    drain();
    set_window(32'h0, 32'hFFFF_FFFF);
    push_op(ara_pkg::MODE_ADD, 32'h1000, 32'h100, 32'h1, 0);
    push_op(ara_pkg::MODE_ADD, 32'h1000, 32'h0, 32'h2, 0);
    push_op(ara_pkg::MODE_ADD, 32'h10F0, 32'h20, 32'h3, 0);
    push_op(ara_pkg::MODE_ADD, 32'h0F80, 32'h100, 32'h3, 0);
    push_op(ara_pkg::MODE_ADD, 32'hFFFF_FF00, 32'h200, 32'h4, 0);
    push_op(ara_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'h1, 32'h4, 0);
    push_op(ara_pkg::MODE_ALLOC, 0, 32'h10, 32'hFFFF_FFFF, 0);
    push_op(ara_pkg::MODE_ALLOC, 0, 32'hFFFF_FFFF, 32'h5, 0);
    push_op(ara_pkg::MODE_VERIFY, 32'h1000, 32'h100, 32'h1, 0);
    push_op(ara_pkg::MODE_VERIFY, 32'h1000, 32'h100, 32'h7, 0);
    push_op(ara_pkg::MODE_DEL, 32'h1000, 32'h0, 32'h2, 0);
    push_op(ara_pkg::MODE_DEL, 32'h1000, 32'h0, 32'h2, 0);
    push_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(3'd7, 0, 0, 0, 0);
    push_op(ara_pkg::MODE_DELALL, 0, 0, 32'h0, 32'h0);
    push_op(ara_pkg::MODE_ALLOC, 0, 32'h10, 0, 0);
    drain();
    // Beyond-RAM cases inside a small window, then fill the table to overflow.
    set_window(32'h8000_0000, 32'h1000);
    push_op(ara_pkg::MODE_ADD, 32'h7FFF_FFF0, 32'h20, 0, 0);
    push_op(ara_pkg::MODE_ADD, 32'h8000_0FF0, 32'h20, 0, 0);
    push_op(ara_pkg::MODE_ADD, 32'h8000_0000, 32'h10, 32'hA, 0);
    for (int i = 0; i < NREG + 1; i++) push_op(ara_pkg::MODE_ALLOC, 0, 32'h10, 32'hB, 0);
    push_op(ara_pkg::MODE_ADD, 32'h8000_0000, 0, 0, 0);
    push_op(ara_pkg::MODE_DELALL, 0, 0, 32'hB, 32'hF);
    drain();

    // Random phases across idle patterns and window settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      case (ph)
        0: set_window(32'h0, 32'h1_0000);
        3: set_window(32'hFFFF_0000, 32'hFFFF_FFFF);
        5: set_window($urandom(), $urandom_range(32'h40000));
        7: set_window(32'hFFFF_FFFF, 32'h0);
        default: ;
      endcase
      random_phase(ph == 7 ? 60 : 140);
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ara_pkg.sv
hw/rtl/ara_ram.sv
hw/rtl/ara_ctrl.sv
hw/rtl/ara_dp.sv
hw/rtl/address_region_allocator.sv
hw/rtl/ara_checker.sv
bench/tb_address_region_allocator.sv
